// ===== hw/rtl/vr_pkg.sv =====
// Shared widths, constants and payload types for the vector refraction block.
package vr_pkg;

  // Component format: signed Q2.(CW-2), one unit is 2^-FRAC
  localparam int CW   = 16;
  localparam int FRAC = CW - 2;

  // Intermediate widths, sized from the worst case of each step
  localparam int TERM_W  = CW + 2;        // one dot product term
  localparam int DOT_W   = CW + 3;        // dot sum and clamped cosine
  localparam int CN_W    = CW + 4;        // v + cos*n
  localparam int PERP_W  = CW + 6;        // eta*(v + cos*n)
  localparam int SQ_W    = CW + 12;       // perp_i^2
  localparam int SUMSQ_W = CW + 13;       // |perp|^2 and |1 - |perp|^2|
  localparam int RAD_W   = 2 * CW + 12;   // square root radicand, even width
  localparam int ROOT_W  = RAD_W / 2;     // root bits, one per sqrt stage
  localparam int REM_W   = ROOT_W + 3;    // partial remainder
  localparam int PAR_W   = CW + 9;        // -root*n
  localparam int FIN_W   = CW + 10;       // perp + par before saturation

  localparam logic [SUMSQ_W-1:0]       FIX_ONE = SUMSQ_W'(1) << FRAC;
  localparam logic signed [DOT_W-1:0]  COS_MAX = DOT_W'(1) << FRAC;
  localparam logic signed [FIN_W-1:0]  OUT_MAX = FIN_W'(2 ** (CW - 1) - 1);
  localparam logic signed [FIN_W-1:0]  OUT_MIN = -OUT_MAX - FIN_W'(1);

  typedef struct packed {
    logic signed [CW-1:0] incident_x;
    logic signed [CW-1:0] incident_y;
    logic signed [CW-1:0] incident_z;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
    logic        [CW-1:0] eta_ratio;
  } refr_req_t;

  typedef struct packed {
    logic signed [CW-1:0] refracted_x;
    logic signed [CW-1:0] refracted_y;
    logic signed [CW-1:0] refracted_z;
  } refr_rsp_t;

  // Values that ride alongside the square root pipeline
  typedef struct packed {
    logic [2:0][PERP_W-1:0] perp;
    logic [2:0][CW-1:0]     nrm;
  } vr_side_t;

endpackage

// ===== hw/rtl/vr_lane.sv =====
// One component lane: dot term, v + cos*n, perpendicular part and its square.
module vr_lane import vr_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [CW-1:0]     vec,
  input  logic signed [CW-1:0]     nrm,
  input  logic        [CW-1:0]     eta,
  input  logic signed [DOT_W-1:0]  cos_val,
  output logic signed [TERM_W-1:0] term,
  output logic signed [PERP_W-1:0] perp,
  output logic        [SQ_W-1:0]   sq,
  output logic signed [CW-1:0]     nrm_dly
);

  logic signed [CW-1:0]     v_d   [2];
  logic signed [CW-1:0]     n_d   [5];
  logic        [CW-1:0]     eta_d [3];
  logic signed [CN_W-1:0]   a_q;
  logic signed [PERP_W-1:0] perp_q;

  logic signed [2*CW-1:0]        vn_prod;
  logic signed [DOT_W+CW-1:0]    cn_prod;
  logic signed [CN_W-1:0]        a_next;
  logic signed [CW+CN_W:0]       pe_prod;
  logic signed [2*PERP_W-1:0]    sq_prod;

  // Products, each floored to the fixed point scale by an arithmetic shift
  assign vn_prod = vec * nrm;
  assign cn_prod = cos_val * n_d[1];
  assign a_next  = CN_W'(v_d[1]) + CN_W'(cn_prod >>> FRAC);
  assign pe_prod = $signed({1'b0, eta_d[2]}) * a_q;
  assign sq_prod = perp_q * perp_q;

  // Stage registers; the cosine comes from the registered merge stage
  always_ff @(posedge clk) begin
    if (adv) begin
      term     <= TERM_W'(vn_prod >>> FRAC);
      v_d[0]   <= vec;
      v_d[1]   <= v_d[0];
      n_d[0]   <= nrm;
      n_d[1]   <= n_d[0];
      n_d[2]   <= n_d[1];
      n_d[3]   <= n_d[2];
      n_d[4]   <= n_d[3];
      eta_d[0] <= eta;
      eta_d[1] <= eta_d[0];
      eta_d[2] <= eta_d[1];
      a_q      <= a_next;
      perp_q   <= PERP_W'(pe_prod >>> FRAC);
      perp     <= perp_q;
      sq       <= SQ_W'(sq_prod >>> FRAC);
    end
  end

  assign nrm_dly = n_d[4];

endmodule

// ===== hw/rtl/vr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband carry.
module vr_sqrt import vr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [SUMSQ_W-1:0] mag,
  input  vr_side_t           side_in,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  root,
  output vr_side_t           side_out
);

  logic               vld_w  [ROOT_W+1];
  logic [REM_W-1:0]   rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0]  root_w [ROOT_W+1];
  logic [RAD_W-1:0]   rad_w  [ROOT_W+1];
  vr_side_t           side_w [ROOT_W+1];

  // Radicand is |1 - |perp|^2| shifted up by FRAC bits
  assign vld_w[0]  = in_valid;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = RAD_W'({mag, {FRAC{1'b0}}});
  assign side_w[0] = side_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] rt;
    logic [RAD_W-1:0]  rad;
    vr_side_t          side;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down two radicand bits and try to subtract 4*root + 1
    assign rem_sh = {rem_w[k][REM_W-3:0], rad_w[k][RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_w[k], 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (adv) begin
        vld <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem  <= take ? rem_sh - trial : rem_sh;
        rt   <= {root_w[k][ROOT_W-2:0], take};
        rad  <= rad_w[k] << 2;
        side <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld;
    assign rem_w[k+1]  = rem;
    assign root_w[k+1] = rt;
    assign rad_w[k+1]  = rad;
    assign side_w[k+1] = side;
  end

  assign out_valid = vld_w[ROOT_W];
  assign root      = root_w[ROOT_W];
  assign side_out  = side_w[ROOT_W];

endmodule

// ===== hw/rtl/vr_out_lane.sv =====
// One output lane: parallel part -root*n, final sum and saturation.
module vr_out_lane import vr_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic        [ROOT_W-1:0] root,
  input  logic signed [PERP_W-1:0] perp,
  input  logic signed [CW-1:0]     nrm,
  output logic signed [CW-1:0]     res
);

  logic signed [ROOT_W:0]      neg_root;
  logic signed [ROOT_W+CW:0]   par_prod;
  logic signed [PAR_W-1:0]     par_q;
  logic signed [PERP_W-1:0]    perp_q;
  logic signed [FIN_W-1:0]     fin;

  assign neg_root = -$signed({1'b0, root});
  assign par_prod = neg_root * nrm;

  always_ff @(posedge clk) begin
    if (adv) begin
      par_q  <= PAR_W'(par_prod >>> FRAC);
      perp_q <= perp;
    end
  end

  // Exact sum, then clamp to the component range
  assign fin = FIN_W'(perp_q) + FIN_W'(par_q);

  always_comb begin
    if (fin > OUT_MAX) begin
      res = CW'(OUT_MAX);
    end else if (fin < OUT_MIN) begin
      res = CW'(OUT_MIN);
    end else begin
      res = CW'(fin);
    end
  end

endmodule

// ===== hw/rtl/vector3_refract_top.sv =====
// Top level of the vector refraction block: lanes, merges, sqrt and output register.
//
// Computes the refracted ray direction perp + par for one request per clock,
// with perp = eta*(v + cos*n), cos = min(-v.n, 1) and par = -sqrt(|1-|perp|^2|)*n,
// all in signed Q2.14 with saturated outputs. Three lanes handle the x, y and z
// components; merge stages form the dot product and |perp|^2 between them.
// Throughput is one request per cycle unless stalled. From request accept to
// response valid, data passes six front stages, the 22-stage square root
// pipeline (one root bit per stage), one parallel-part stage and the output
// register. The whole pipeline advances together: while a response
// waits untaken in the output register, req_ready is low.
module vector3_refract_top import vr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  refr_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output refr_rsp_t rsp
);

  logic adv;

  logic signed [CW-1:0]     vin  [3];
  logic signed [CW-1:0]     nin  [3];
  logic signed [TERM_W-1:0] term [3];
  logic signed [PERP_W-1:0] perp [3];
  logic        [SQ_W-1:0]   sq   [3];
  logic signed [CW-1:0]     ndly [3];
  logic signed [CW-1:0]     res  [3];

  logic [5:0]               vld;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  neg_dot;
  logic signed [DOT_W-1:0]  cos_q;
  logic [SUMSQ_W-1:0]       sumsq;
  logic [SUMSQ_W-1:0]       mag_q;
  vr_side_t                 side_q;
  vr_side_t                 side_out;
  logic                     sq_valid;
  logic [ROOT_W-1:0]        root;
  logic                     par_vld;

  // Whole pipeline moves when the output register is free or being drained
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  assign vin[0] = req.incident_x;
  assign vin[1] = req.incident_y;
  assign vin[2] = req.incident_z;
  assign nin[0] = req.normal_x;
  assign nin[1] = req.normal_y;
  assign nin[2] = req.normal_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vr_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .vec     (vin[i]),
      .nrm     (nin[i]),
      .eta     (req.eta_ratio),
      .cos_val (cos_q),
      .term    (term[i]),
      .perp    (perp[i]),
      .sq      (sq[i]),
      .nrm_dly (ndly[i])
    );
  end

  // Merge: dot product and cosine clamped above at one
  assign dot     = DOT_W'(term[0]) + DOT_W'(term[1]) + DOT_W'(term[2]);
  assign neg_dot = -dot;

  // Merge: |perp|^2 and its distance from one
  assign sumsq = SUMSQ_W'(sq[0]) + SUMSQ_W'(sq[1]) + SUMSQ_W'(sq[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q  <= (neg_dot > COS_MAX) ? COS_MAX : neg_dot;
      mag_q  <= (sumsq > FIX_ONE) ? sumsq - FIX_ONE : FIX_ONE - sumsq;
      for (int i = 0; i < 3; i++) begin
        side_q.perp[i] <= perp[i];
        side_q.nrm[i]  <= ndly[i];
      end
    end
  end

  // Valid chain for the six front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], req_valid};
    end
  end

  vr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vld[5]),
    .mag       (mag_q),
    .side_in   (side_q),
    .out_valid (sq_valid),
    .root      (root),
    .side_out  (side_out)
  );

  for (genvar i = 0; i < 3; i++) begin : g_out
    vr_out_lane u_out (
      .clk  (clk),
      .adv  (adv),
      .root (root),
      .perp ($signed(side_out.perp[i])),
      .nrm  ($signed(side_out.nrm[i])),
      .res  (res[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      par_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      par_vld   <= sq_valid;
      rsp_valid <= par_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.refracted_x <= res[0];
      rsp.refracted_y <= res[1];
      rsp.refracted_z <= res[2];
    end
  end

endmodule

// ===== hw/rtl/vr_checker.sv =====
// Port-level checks for the vector refraction block, bound to the top level.
module vr_checker import vr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input refr_rsp_t rsp
);

  // A stalled response keeps its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // An empty output register never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked with output register empty");

  // Pipeline is stalled while a response waits
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while pipeline stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind vector3_refract_top vr_checker u_vr_checker (.*);
